// ===== src/font_rom_glyph_address_generator_macros.svh =====
// assertion macros for the font rom glyph address generator
`ifndef FONT_ROM_GLYPH_ADDRESS_GENERATOR_MACROS_SVH
`define FONT_ROM_GLYPH_ADDRESS_GENERATOR_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define FRGA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frga check failed");
// antecedent implies consequent in the cycle after
`define FRGA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frga check failed");
`else
`define FRGA_ASSERT_NOW(lbl, ante, cons)
`define FRGA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/frga_pkg.sv =====
// shared types, constants and font table of the glyph address generator
`default_nettype none
package frga_pkg;

	localparam int InWidth  = 40;
	localparam int OutWidth = 80;
	localparam int IdxWidth = 13;

	localparam logic [7:0] SymLeadLo   = 8'hA1;
	localparam logic [7:0] SymLeadHi   = 8'hA9;
	localparam logic [7:0] HanLeadLo   = 8'hB0;
	localparam logic [7:0] HanLeadHi   = 8'hF7;
	localparam logic [7:0] TrailLo     = 8'hA1;
	localparam logic [7:0] AscLo       = 8'h20;
	localparam logic [7:0] AscHi       = 8'h7E;
	localparam logic [6:0] RowLen      = 7'd94;
	localparam logic [9:0] HanOffset   = 10'd846;

	localparam logic CmdStart = 1'b0;
	localparam logic CmdText  = 1'b1;
	localparam logic SetGb    = 1'b0;
	localparam logic SetAscii = 1'b1;

	localparam logic RegFontSet  = 1'b0;
	localparam logic RegFontSize = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} frga_state_t;

	typedef struct packed {
		logic take_in;
		logic load_out;
	} frga_cmd_t;

	typedef struct packed {
		logic emit;
	} frga_status_t;

	typedef struct packed {
		logic        valid;
		logic [23:0] base;
		logic [7:0]  count;
		logic [5:0]  adv;
		logic [5:0]  w;
		logic [5:0]  h;
	} font_desc_t;

	function automatic font_desc_t font_lookup(input logic set, input logic [2:0] size);
		font_desc_t f;
		f = '0;
		if (set == SetGb) begin
			case (size)
				3'd1: f = '{1'b1, 24'h000000, 8'd24, 6'd12, 6'd16, 6'd12};
				3'd2: f = '{1'b1, 24'h02C9D0, 8'd32, 6'd16, 6'd16, 6'd16};
				3'd3: f = '{1'b1, 24'h068190, 8'd72, 6'd24, 6'd24, 6'd24};
				3'd4: f = '{1'b1, 24'h0EDF00, 8'd128, 6'd32, 6'd32, 6'd32};
				default: f = '0;
			endcase
		end else begin
			case (size)
				3'd1: f = '{1'b1, 24'h1DDF80, 8'd8, 6'd6, 6'd8, 6'd8};
				3'd2: f = '{1'b1, 24'h1DE280, 8'd8, 6'd8, 6'd8, 6'd8};
				3'd3: f = '{1'b1, 24'h1DBE00, 8'd12, 6'd6, 6'd8, 6'd12};
				3'd4: f = '{1'b1, 24'h1DD780, 8'd16, 6'd8, 6'd8, 6'd16};
				3'd5: f = '{1'b1, 24'h1DFF00, 8'd48, 6'd12, 6'd16, 6'd24};
				3'd6: f = '{1'b1, 24'h1E5A50, 8'd64, 6'd16, 6'd16, 6'd32};
				default: f = '0;
			endcase
		end
		return f;
	endfunction

endpackage
`default_nettype wire

// ===== src/frga_ctrl.sv =====
// controller: request sequencing and output register ownership
`default_nettype none
module frga_ctrl import frga_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire frga_status_t status,
	output frga_cmd_t         cmd
);

	frga_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_CALC;
			end
			ST_CALC: begin
				if (!status.emit || out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.take_in  = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.take_in = s_tvalid;
			end
			ST_CALC: begin
				cmd.load_out = status.emit && out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== src/frga_datapath.sv =====
// datapath: text decode, pen state, glyph index and rom address
`default_nettype none
module frga_datapath import frga_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [2:0]          cfg_data,
	input  wire logic                s_tuser,
	input  wire logic [InWidth-1:0]  s_tdata,
	input  wire frga_cmd_t           cmd,
	output frga_status_t             status,
	output logic [OutWidth-1:0]      m_tdata
);

	logic        font_set_q;
	logic [2:0]  font_size_q;
	logic [7:0]  pending_lead_q;
	logic        lead_valid_q;
	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;

	logic [15:0] in_x, in_y;
	logic [7:0]  in_byte;
	font_desc_t  f;

	logic              is_sym, is_han, trail_ok, asc_ok;
	logic [6:0]        row;
	logic [13:0]       row_prod;
	logic [7:0]        trail_off;
	logic [IdxWidth-1:0] gb_idx, asc_idx;
	logic [15:0]       cursor_next;

	logic                emit_s1;
	logic [IdxWidth-1:0] idx_s1;
	logic [23:0]         base_s1;
	logic [7:0]          count_s1;
	logic [5:0]          w_s1, h_s1;
	logic [15:0]         gx_s1, gy_s1;

	logic [20:0] addr_prod;
	logic [23:0] addr_sum;

	logic [23:0] addr_q;
	logic [7:0]  count_q;
	logic [15:0] gx_q, gy_q;
	logic [5:0]  w_q, h_q;

	assign in_x    = s_tdata[15:0];
	assign in_y    = s_tdata[31:16];
	assign in_byte = s_tdata[39:32];
	assign f       = font_lookup(font_set_q, font_size_q);

	// glyph index of a gb2312 pair, symbol rows first then hanzi
	assign is_sym    = (pending_lead_q >= SymLeadLo) && (pending_lead_q <= SymLeadHi);
	assign is_han    = (pending_lead_q >= HanLeadLo) && (pending_lead_q <= HanLeadHi);
	assign trail_ok  = in_byte >= TrailLo;
	assign row       = is_sym ? 7'(pending_lead_q - SymLeadLo) : 7'(pending_lead_q - HanLeadLo);
	assign row_prod  = row * RowLen;
	assign trail_off = in_byte - TrailLo;
	assign gb_idx    = IdxWidth'(row_prod) + IdxWidth'(trail_off)
		+ (is_sym ? '0 : IdxWidth'(HanOffset));
	assign asc_ok    = (in_byte >= AscLo) && (in_byte <= AscHi);
	assign asc_idx   = IdxWidth'(in_byte - AscLo);
	assign cursor_next = cursor_x_q + {10'd0, f.adv};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_set_q  <= SetGb;
			font_size_q <= 3'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				RegFontSet:  font_set_q  <= cfg_data[0];
				RegFontSize: font_size_q <= cfg_data;
				default:     font_size_q <= font_size_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_valid_q <= 1'b0;
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			emit_s1      <= 1'b0;
		end else if (cmd.take_in) begin
			if (s_tuser == CmdStart) begin
				emit_s1      <= 1'b0;
				cursor_x_q   <= in_x;
				cursor_y_q   <= in_y;
				lead_valid_q <= 1'b0;
			end else if (in_byte == 8'd0) begin
				emit_s1      <= 1'b0;
				lead_valid_q <= 1'b0;
			end else if (font_set_q == SetAscii) begin
				lead_valid_q <= 1'b0;
				emit_s1      <= f.valid && asc_ok;
				if (f.valid) cursor_x_q <= cursor_next;
			end else if (!lead_valid_q) begin
				emit_s1      <= 1'b0;
				lead_valid_q <= 1'b1;
			end else begin
				lead_valid_q <= 1'b0;
				emit_s1      <= f.valid && trail_ok && (is_sym || is_han);
				if (f.valid) cursor_x_q <= cursor_next;
			end
		end
	end

	// payload side of the decode stage
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			if (s_tuser == CmdText && font_set_q == SetGb && !lead_valid_q)
				pending_lead_q <= in_byte;
			idx_s1   <= (font_set_q == SetAscii) ? asc_idx : gb_idx;
			base_s1  <= f.base;
			count_s1 <= f.count;
			w_s1     <= f.w;
			h_s1     <= f.h;
			gx_s1    <= cursor_x_q;
			gy_s1    <= cursor_y_q;
		end
	end

	assign status.emit = emit_s1;

	assign addr_prod = idx_s1 * count_s1;
	assign addr_sum  = {3'd0, addr_prod} + base_s1;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			addr_q  <= addr_sum;
			count_q <= count_s1;
			gx_q    <= gx_s1;
			gy_q    <= gy_s1;
			w_q     <= w_s1;
			h_q     <= h_s1;
		end
	end

	assign m_tdata = {4'd0, h_q, w_q, gy_q, gx_q, count_q, addr_q};

endmodule
`default_nettype wire

// ===== src/font_rom_glyph_address_generator.sv =====
// top level of the font rom glyph address generator
`default_nettype none
`include "font_rom_glyph_address_generator_macros.svh"
// Takes start requests (tuser low: pen x and row y) and text byte requests (tuser high) and
// gives one request per drawable glyph with its font rom address, bitmap byte count, pen
// position and window size. Each input is handled in order: the decode stage turns the byte or
// gb2312 pair into a registered glyph index, then the index times byte count multiply and
// base add go into the output register. A result still waiting at the output holds the next
// multiply step until it is taken; the next input is taken while a result waits. The user
// writes font set and size through the cfg port only while idle; the block does not enforce it.
module font_rom_glyph_address_generator import frga_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [2:0]          cfg_data,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [InWidth-1:0]  s_tdata,  // start_x, start_y, text_byte
	input  wire logic                s_tuser,  // cmd
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// rom_address, byte_count, glyph_x, glyph_y, win_width, win_height, zero pad
	output logic [OutWidth-1:0]      m_tdata
);

	frga_cmd_t    cmd;
	frga_status_t status;

	frga_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	frga_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tdata   (m_tdata)
	);

	// an accepted request is always followed by the compute cycle
	`FRGA_ASSERT_NEXT(a_accept_then_busy, s_tvalid && s_tready, !s_tready)
	// a loaded result shows up at the output
	`FRGA_ASSERT_NEXT(a_load_shows, cmd.load_out, m_tvalid)
	// never overwrite a result that has not been taken
	`FRGA_ASSERT_NOW(a_no_overwrite, cmd.load_out, !m_tvalid || m_tready)

endmodule
`default_nettype wire

// ===== bench/glyph_request_checker.sv =====
`timescale 1ns / 100ps
// watches the request, glyph and config ports, works out each glyph request and compares
module glyph_request_checker import frga_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [2:0]          cfg_data,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [InWidth-1:0]  s_tdata,  // start_x, start_y, text_byte
	input  logic                s_tuser,  // cmd
	input  logic                m_tvalid,
	input  logic                m_tready,
	// rom_address, byte_count, glyph_x, glyph_y, win_width, win_height, zero pad
	input  logic [OutWidth-1:0] m_tdata,
	output int                  mismatches,
	output int                  glyphs_due
);

	typedef struct packed {
		logic        ok;
		logic [23:0] base;
		logic [7:0]  count;
		logic [5:0]  adv;
		logic [5:0]  w;
		logic [5:0]  h;
	} glyph_font_t;

	typedef struct packed {
		logic [5:0]  h;
		logic [5:0]  w;
		logic [15:0] y;
		logic [15:0] x;
		logic [7:0]  count;
		logic [23:0] addr;
	} glyph_req_t;

	glyph_req_t  pending_glyphs [$];
	logic        font_set_q;
	logic [2:0]  font_size_q;
	logic [7:0]  lead_byte;
	logic        lead_held;
	logic [15:0] pen_x;
	logic [15:0] pen_y;

	initial mismatches = 0;

	function automatic glyph_font_t font_of(input logic set, input logic [2:0] size);
		glyph_font_t f;
		f = '0;
		if (set == SetGb) begin
			case (size)
				3'd1: f = '{1'b1, 24'h000000, 8'd24, 6'd12, 6'd16, 6'd12};
				3'd2: f = '{1'b1, 24'h02C9D0, 8'd32, 6'd16, 6'd16, 6'd16};
				3'd3: f = '{1'b1, 24'h068190, 8'd72, 6'd24, 6'd24, 6'd24};
				3'd4: f = '{1'b1, 24'h0EDF00, 8'd128, 6'd32, 6'd32, 6'd32};
				default: f = '0;
			endcase
		end else begin
			case (size)
				3'd1: f = '{1'b1, 24'h1DDF80, 8'd8, 6'd6, 6'd8, 6'd8};
				3'd2: f = '{1'b1, 24'h1DE280, 8'd8, 6'd8, 6'd8, 6'd8};
				3'd3: f = '{1'b1, 24'h1DBE00, 8'd12, 6'd6, 6'd8, 6'd12};
				3'd4: f = '{1'b1, 24'h1DD780, 8'd16, 6'd8, 6'd8, 6'd16};
				3'd5: f = '{1'b1, 24'h1DFF00, 8'd48, 6'd12, 6'd16, 6'd24};
				3'd6: f = '{1'b1, 24'h1E5A50, 8'd64, 6'd16, 6'd16, 6'd32};
				default: f = '0;
			endcase
		end
		return f;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] glyph mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// one request in, at most one glyph out
	task automatic predict_glyph(input logic cmd, input logic [15:0] sx, input logic [15:0] sy,
			input logic [7:0] ch);
		glyph_font_t f;
		glyph_req_t  g;
		logic        drawn;
		logic        moved;
		int unsigned idx;
		int unsigned addr;
		drawn = 1'b0;
		moved = 1'b0;
		idx = 0;
		f = '0;
		if (cmd == CmdStart) begin
			pen_x = sx;
			pen_y = sy;
			lead_held = 1'b0;
			lead_byte = 8'h00;
		end else if (ch == 8'h00) begin
			// end of string: a half pair is lost, the pen stays
			lead_held = 1'b0;
			lead_byte = 8'h00;
		end else if (font_set_q == SetAscii) begin
			lead_held = 1'b0;
			lead_byte = 8'h00;
			f = font_of(SetAscii, font_size_q);
			moved = f.ok;
			if (f.ok && ch >= AscLo && ch <= AscHi) begin
				drawn = 1'b1;
				idx = ch - AscLo;
			end
		end else if (!lead_held) begin
			lead_byte = ch;
			lead_held = 1'b1;
		end else begin
			f = font_of(SetGb, font_size_q);
			moved = f.ok;
			if (f.ok && ch >= TrailLo) begin
				if (lead_byte >= SymLeadLo && lead_byte <= SymLeadHi) begin
					drawn = 1'b1;
					idx = (lead_byte - SymLeadLo) * RowLen + (ch - TrailLo);
				end else if (lead_byte >= HanLeadLo && lead_byte <= HanLeadHi) begin
					drawn = 1'b1;
					idx = (lead_byte - HanLeadLo) * RowLen + (ch - TrailLo) + HanOffset;
				end
			end
			lead_held = 1'b0;
			lead_byte = 8'h00;
		end
		if (drawn) begin
			addr = idx * f.count + f.base;
			g.addr  = addr[23:0];
			g.count = f.count;
			g.x     = pen_x;
			g.y     = pen_y;
			g.w     = f.w;
			g.h     = f.h;
			pending_glyphs.push_back(g);
		end
		if (moved)
			pen_x = pen_x + f.adv;
	endtask

	always @(posedge clk or negedge arst_n) begin
		glyph_req_t want;
		if (!arst_n) begin
			pending_glyphs.delete();
			font_set_q = SetGb;
			font_size_q = 3'd1;
			lead_byte = 8'h00;
			lead_held = 1'b0;
			pen_x = 16'h0000;
			pen_y = 16'h0000;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_glyphs.size() == 0) begin
					report_mismatch($sformatf("unexpected glyph request 0x%0h", m_tdata));
				end else begin
					want = pending_glyphs.pop_front();
					check_field("rom_address", m_tdata[23:0], want.addr);
					check_field("byte_count", m_tdata[31:24], want.count);
					check_field("glyph_x", m_tdata[47:32], want.x);
					check_field("glyph_y", m_tdata[63:48], want.y);
					check_field("win_width", m_tdata[69:64], want.w);
					check_field("win_height", m_tdata[75:70], want.h);
					check_field("pad", m_tdata[OutWidth-1:76], 0);
				end
			end
			if (s_tvalid && s_tready)
				predict_glyph(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[39:32]);
			if (cfg_we) begin
				if (cfg_index == RegFontSet)
					font_set_q = cfg_data[0];
				else
					font_size_q = cfg_data;
			end
		end
		glyphs_due = pending_glyphs.size();
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// top of the glyph address generator bench: clock, reset, text requests and the verdict
module testbench;
	import frga_pkg::*;

	// font set and size of each random batch, unsupported sizes among them
	localparam logic [3:0] Plan [16] = '{
		{SetGb, 3'd1}, {SetAscii, 3'd1}, {SetGb, 3'd4}, {SetAscii, 3'd6},
		{SetGb, 3'd0}, {SetAscii, 3'd7}, {SetGb, 3'd2}, {SetAscii, 3'd5},
		{SetGb, 3'd7}, {SetAscii, 3'd0}, {SetGb, 3'd3}, {SetAscii, 3'd2},
		{SetGb, 3'd5}, {SetAscii, 3'd3}, {SetGb, 3'd6}, {SetAscii, 3'd4}
	};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [2:0]          cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [InWidth-1:0]  s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutWidth-1:0] m_tdata;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	int                  mismatches;
	int                  glyphs_due;

	font_rom_glyph_address_generator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	glyph_request_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.mismatches(mismatches),
		.glyphs_due(glyphs_due)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#1_000_000;
		$display("font_rom_glyph_address_generator test failed");
		$finish;
	end

	task automatic send_req(input logic cmd, input logic [15:0] sx, input logic [15:0] sy,
			input logic [7:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {ch, sy, sx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] ch);
		send_req(CmdText, 16'($urandom), 16'($urandom), ch);
	endtask

	// let every glyph come out and any silent request finish
	task automatic quiesce();
		s_tvalid = 1'b0;
		while (glyphs_due != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [2:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic select_font(input logic set, input logic [2:0] size);
		quiesce();
		write_reg(RegFontSet, {2'b00, set});
		write_reg(RegFontSize, size);
	endtask

	task automatic random_batch(input logic set, input int n);
		int         sent;
		int         pick;
		logic [7:0] lead;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				// starts near the top of x make the pen wrap
				send_req(CmdStart,
					($urandom_range(3) == 0) ? {12'hFFF, 4'($urandom)} : 16'($urandom),
					16'($urandom), 8'($urandom));
				sent++;
			end else if (pick < 14) begin
				send_text(8'($urandom));
				sent++;
			end else if (pick < 17) begin
				send_text(8'h00);
				sent++;
			end else if (set == SetAscii) begin
				send_text(8'($urandom_range(AscHi, AscLo)));
				sent++;
			end else begin
				lead = $urandom_range(1) ? 8'($urandom_range(SymLeadHi, SymLeadLo))
					: 8'($urandom_range(HanLeadHi, HanLeadLo));
				send_text(lead);
				send_text(($urandom_range(9) == 0) ? 8'($urandom)
					: 8'($urandom_range(8'hFE, TrailLo)));
				sent += 2;
			end
		end
	endtask

	initial begin
		logic set;
		logic [2:0] size;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = RegFontSet;
		cfg_data = 3'd0;
		s_tvalid = 1'b0;
		s_tuser = CmdStart;
		s_tdata = '0;
		m_tready = 1'b0;
		send_idle_pct = 29;
		recv_stall_pct = 80;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// gb2312 corners: pen starts near the top so x wraps
		select_font(SetGb, 3'd1);
		send_req(CmdStart, 16'hFFF0, 16'hFFFF, 8'h00);
		send_text(8'hA1); send_text(8'hA1);
		send_text(8'hA9); send_text(8'hFE);
		send_text(8'hB0); send_text(8'hA1);
		send_text(8'hF7); send_text(8'hFE);
		send_text(8'hAA); send_text(8'hA1);
		send_text(8'hB0); send_text(8'hA0);
		send_text(8'hA1); send_text(8'h00);
		send_text(8'hFF); send_text(8'hA1);
		// a start in the middle of a pair drops the lead
		send_text(8'hB5);
		send_req(CmdStart, 16'h0000, 16'h0000, 8'hFF);
		send_text(8'hA1); send_text(8'hFF);
		// lone lead, dropped by the first ascii byte
		send_text(8'hB1);
		select_font(SetAscii, 3'd1);
		send_text(8'h20);
		send_text(8'h7E);
		send_text(8'h1F);
		send_text(8'h7F);
		send_text(8'h00);

		for (int b = 0; b < 16; b++) begin
			set  = Plan[b][3];
			size = Plan[b][2:0];
			if (b < 5) begin
				send_idle_pct = 29;
				recv_stall_pct = 80;
			end else if (b < 11) begin
				send_idle_pct = 80;
				recv_stall_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			select_font(set, size);
			if (size != 3'd0 && (size <= 3'd4 || (set == SetAscii && size <= 3'd6)))
				random_batch(set, 120);
			else
				random_batch(set, 30);
		end

		s_tvalid = 1'b0;
		while (glyphs_due != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("font_rom_glyph_address_generator test passed");
		else
			$display("font_rom_glyph_address_generator test failed");
		$finish;
	end

endmodule
